// File: rtl/core/tgfb_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the tile grid fill and brush unit
// no dependencies; used by every module of the block

package tgfb_pkg;

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_TILE_BITS  = 5;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 7;
    localparam int TILE_W     = 5;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int RADIUS_W   = 2;
    localparam int OFF_W      = 3;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0]  CFG_MAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0]  CFG_BRUSH_RADIUS = 2'd2;
    localparam logic [CFG_DATA_W-1:0] RST_MAP_WIDTH    = 8'd128;
    localparam logic [CFG_DATA_W-1:0] RST_MAP_HEIGHT   = 8'd128;
    localparam logic [RADIUS_W-1:0]   RST_BRUSH_RADIUS = 2'd0;
    localparam logic [RADIUS_W-1:0]   MAX_RADIUS       = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BRUSH = 2'd2,
        OP_FILL  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_NO_CHANGE = 2'd2
    } t_status;

    // fill neighbor order: up, down, left, right
    localparam logic signed [OFF_W-1:0] STEP_DX [4] = '{3'sd0, 3'sd0, -3'sd1, 3'sd1};
    localparam logic signed [OFF_W-1:0] STEP_DY [4] = '{-3'sd1, 3'sd1, 3'sd0, 3'sd0};

    // stack control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

endpackage

// File: rtl/core/tgfb_coord_unit.sv
`timescale 1ns / 1ps
// shared coordinate unit: offset add, map bounds compare and cell address
// depends on tgfb_pkg

module tgfb_coord_unit #(
    parameter int MAX_WIDTH  = tgfb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tgfb_pkg::DEF_MAX_HEIGHT
) (
    i_base_x, i_base_y, i_off_x, i_off_y, i_used_w, i_used_h,
    o_inside, o_x, o_y, o_index
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int CXW = (XW > tgfb_pkg::COORD_W) ? XW : tgfb_pkg::COORD_W;
    localparam int CYW = (YW > tgfb_pkg::COORD_W) ? YW : tgfb_pkg::COORD_W;
    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int SXW = CXW + 2;
    localparam int SYW = CYW + 2;

    input  logic [CXW-1:0]                       i_base_x;
    input  logic [CYW-1:0]                       i_base_y;
    input  logic signed [tgfb_pkg::OFF_W-1:0]    i_off_x;
    input  logic signed [tgfb_pkg::OFF_W-1:0]    i_off_y;
    input  logic [CXW:0]                         i_used_w;
    input  logic [CYW:0]                         i_used_h;
    output logic                                 o_inside;
    output logic [XW-1:0]                        o_x;
    output logic [YW-1:0]                        o_y;
    output logic [AW-1:0]                        o_index;

    logic signed [SXW-1:0] w_sx;
    logic signed [SYW-1:0] w_sy;

    assign w_sx = signed'({2'b00, i_base_x}) + SXW'(i_off_x);
    assign w_sy = signed'({2'b00, i_base_y}) + SYW'(i_off_y);

    // negative or past the used edge is off the map
    assign o_inside = !w_sx[SXW-1] && (w_sx[CXW:0] < i_used_w) &&
                      !w_sy[SYW-1] && (w_sy[CYW:0] < i_used_h);

    assign o_x     = w_sx[XW-1:0];
    assign o_y     = w_sy[YW-1:0];
    assign o_index = AW'(AW'(o_y) * AW'(MAX_WIDTH) + AW'(o_x));

endmodule

// File: rtl/core/tgfb_fill_stack.sv
`timescale 1ns / 1ps
// stack of pending fill cells with registered pop data
// depends on tgfb_pkg

module tgfb_fill_stack #(
    parameter int DEPTH = tgfb_pkg::DEF_MAX_WIDTH * tgfb_pkg::DEF_MAX_HEIGHT,
    parameter int WIDTH = $clog2(tgfb_pkg::DEF_MAX_WIDTH) + $clog2(tgfb_pkg::DEF_MAX_HEIGHT)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tgfb_pkg::t_stk_cmd           i_cmd,
    input  logic [WIDTH-1:0]             i_push_data,
    output logic [WIDTH-1:0]             o_pop_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    w_top;

    assign w_top = r_count - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.pop) begin
            r_count <= w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[AW-1:0]] <= i_push_data;
        end
        if (i_cmd.pop) begin
            o_pop_data <= r_mem[w_top[AW-1:0]];
        end
    end

    assign o_count = r_count;

endmodule

// File: rtl/core/tile_grid_fill_and_brush_unit.sv
`timescale 1ns / 1ps
// top level of the tile grid: cell write/read, square brush, 4-connected fill
// depends on tgfb_pkg, tgfb_coord_unit, tgfb_fill_stack
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | i_in_valid/o_in_ready, opcode, x, y, tile      | input
//  out     | o_out_valid/i_out_ready, read_tile, status, n  | output
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data (no wait)      | input
//
// one item at a time; a sequencer drives one shared coordinate unit
// brush steps through each cell of the (2r+1) square in turn
// fill: seeds the start cell, then pops each cell and checks its neighbors;
//   the single grid read port sets the fill pace
// the next item is taken while a result waits in the output register
// reset is synchronous; grid and stack contents need no clearing pass

module tile_grid_fill_and_brush_unit #(
    parameter int MAX_WIDTH  = tgfb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tgfb_pkg::DEF_MAX_HEIGHT,
    parameter int TILE_BITS  = tgfb_pkg::DEF_TILE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [tgfb_pkg::OP_W-1:0]          i_opcode,
    input  logic [tgfb_pkg::COORD_W-1:0]       i_x_coord,
    input  logic [tgfb_pkg::COORD_W-1:0]       i_y_coord,
    input  logic [tgfb_pkg::TILE_W-1:0]        i_tile_value,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tgfb_pkg::TILE_W-1:0]        o_read_tile,
    output logic [tgfb_pkg::STATUS_W-1:0]      o_status,
    output logic [tgfb_pkg::COUNT_W-1:0]       o_cells_changed,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [tgfb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tgfb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CXW   = (XW > tgfb_pkg::COORD_W) ? XW : tgfb_pkg::COORD_W;
    localparam int CYW   = (YW > tgfb_pkg::COORD_W) ? YW : tgfb_pkg::COORD_W;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int SW    = XW + YW;
    localparam int OW    = tgfb_pkg::OFF_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RDWAIT,
        S_BRUSH,
        S_FSEED,
        S_POP,
        S_PWAIT,
        S_NREAD,
        S_NCHK,
        S_RESULT
    } t_state;

    t_state                              r_state;
    tgfb_pkg::t_opcode                   r_op;
    logic [CXW-1:0]                      r_x;
    logic [CYW-1:0]                      r_y;
    logic [TILE_BITS-1:0]                r_tile;
    logic [TILE_BITS-1:0]                r_old;
    logic [CXW-1:0]                      r_cx;
    logic [CYW-1:0]                      r_cy;
    logic [1:0]                          r_dir;
    logic signed [OW-1:0]                r_bdx;
    logic signed [OW-1:0]                r_bdy;
    logic signed [OW-1:0]                r_rad;
    logic [CNTW-1:0]                     r_cnt;
    logic [tgfb_pkg::TILE_W-1:0]         r_res_tile;
    tgfb_pkg::t_status                   r_res_status;

    logic                                r_out_valid;
    logic [tgfb_pkg::TILE_W-1:0]         r_out_tile;
    tgfb_pkg::t_status                   r_out_status;
    logic [tgfb_pkg::COUNT_W-1:0]        r_out_cnt;

    logic [tgfb_pkg::CFG_DATA_W-1:0]     r_map_w;
    logic [tgfb_pkg::CFG_DATA_W-1:0]     r_map_h;
    logic [tgfb_pkg::RADIUS_W-1:0]       r_brush_r;

    logic [TILE_BITS-1:0]                r_grid [CELLS];
    logic [TILE_BITS-1:0]                r_grid_rd;

    logic                                w_in_acc;
    logic                                w_res_load;
    logic [CXW:0]                        w_used_w;
    logic [CYW:0]                        w_used_h;
    logic [CXW-1:0]                      w_base_x;
    logic [CYW-1:0]                      w_base_y;
    logic signed [OW-1:0]                w_off_x;
    logic signed [OW-1:0]                w_off_y;
    logic                                w_inside;
    logic [XW-1:0]                       w_nx;
    logic [YW-1:0]                       w_ny;
    logic [AW-1:0]                       w_idx;
    logic                                w_gwe;
    logic                                w_gre;
    logic                                w_match;
    logic                                w_room;
    logic [tgfb_pkg::RADIUS_W-1:0]       w_rad;
    tgfb_pkg::t_stk_cmd                  w_stk_cmd;
    logic [SW-1:0]                       w_stk_rd;
    logic [CNTW-1:0]                     w_stk_cnt;

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);

    // finished result moves into the output register once that is free
    assign w_res_load = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);

    // map size saturates at the grid size
    assign w_used_w = ((CXW+1)'(r_map_w) > (CXW+1)'(MAX_WIDTH)) ?
                      (CXW+1)'(MAX_WIDTH) : (CXW+1)'(r_map_w);
    assign w_used_h = ((CYW+1)'(r_map_h) > (CYW+1)'(MAX_HEIGHT)) ?
                      (CYW+1)'(MAX_HEIGHT) : (CYW+1)'(r_map_h);

    assign w_rad = (r_brush_r > tgfb_pkg::MAX_RADIUS) ? tgfb_pkg::MAX_RADIUS : r_brush_r;

    // operand select for the shared coordinate unit
    always_comb begin
        w_base_x = r_x;
        w_base_y = r_y;
        w_off_x  = '0;
        w_off_y  = '0;
        case (r_state)
            S_BRUSH: begin
                w_off_x = r_bdx;
                w_off_y = r_bdy;
            end
            S_NREAD, S_NCHK: begin
                w_base_x = r_cx;
                w_base_y = r_cy;
                w_off_x  = tgfb_pkg::STEP_DX[r_dir];
                w_off_y  = tgfb_pkg::STEP_DY[r_dir];
            end
            default: begin
                w_base_x = r_x;
                w_base_y = r_y;
            end
        endcase
    end

    tgfb_coord_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_coord (
        .i_base_x (w_base_x),
        .i_base_y (w_base_y),
        .i_off_x  (w_off_x),
        .i_off_y  (w_off_y),
        .i_used_w (w_used_w),
        .i_used_h (w_used_h),
        .o_inside (w_inside),
        .o_x      (w_nx),
        .o_y      (w_ny),
        .o_index  (w_idx)
    );

    assign w_match = (r_grid_rd == r_old);
    assign w_room  = (w_stk_cnt < CNTW'(CELLS));

    // grid and stack strobes
    always_comb begin
        w_gwe          = 1'b0;
        w_gre          = 1'b0;
        w_stk_cmd.push = 1'b0;
        w_stk_cmd.pop  = 1'b0;
        case (r_state)
            S_DISPATCH: begin
                w_gwe = w_inside && (r_op == tgfb_pkg::OP_WRITE);
                w_gre = w_inside && ((r_op == tgfb_pkg::OP_READ) ||
                                     (r_op == tgfb_pkg::OP_FILL));
            end
            S_BRUSH: begin
                w_gwe = w_inside;
            end
            S_FSEED: begin
                w_gwe          = (r_grid_rd != r_tile);
                w_stk_cmd.push = (r_grid_rd != r_tile);
            end
            S_POP: begin
                w_stk_cmd.pop = (w_stk_cnt != '0);
            end
            S_NREAD: begin
                w_gre = w_inside;
            end
            S_NCHK: begin
                w_gwe          = w_match && w_room;
                w_stk_cmd.push = w_match && w_room;
            end
            default: begin
                w_gwe = 1'b0;
            end
        endcase
    end

    tgfb_fill_stack #(
        .DEPTH (CELLS),
        .WIDTH (SW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_stk_cmd),
        .i_push_data ({w_ny, w_nx}),
        .o_pop_data  (w_stk_rd),
        .o_count     (w_stk_cnt)
    );

    // tile grid, one port shared by read and write
    always_ff @(posedge i_clk) begin
        if (w_gwe) begin
            r_grid[w_idx] <= r_tile;
        end
        if (w_gre) begin
            r_grid_rd <= r_grid[w_idx];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w   <= tgfb_pkg::RST_MAP_WIDTH;
            r_map_h   <= tgfb_pkg::RST_MAP_HEIGHT;
            r_brush_r <= tgfb_pkg::RST_BRUSH_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tgfb_pkg::CFG_MAP_WIDTH:    r_map_w   <= i_cfg_data;
                tgfb_pkg::CFG_MAP_HEIGHT:   r_map_h   <= i_cfg_data;
                tgfb_pkg::CFG_BRUSH_RADIUS: r_brush_r <= i_cfg_data[tgfb_pkg::RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= tgfb_pkg::t_opcode'(i_opcode);
                        r_x     <= CXW'(i_x_coord);
                        r_y     <= CYW'(i_y_coord);
                        r_tile  <= TILE_BITS'(i_tile_value);
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_res_tile   <= '0;
                    r_cnt        <= (w_inside && (r_op == tgfb_pkg::OP_WRITE)) ?
                                    CNTW'(1) : '0;
                    r_res_status <= w_inside ? tgfb_pkg::ST_DONE : tgfb_pkg::ST_OUTSIDE;
                    case (r_op)
                        tgfb_pkg::OP_WRITE: begin
                            r_state <= S_RESULT;
                        end
                        tgfb_pkg::OP_READ: begin
                            r_state <= w_inside ? S_RDWAIT : S_RESULT;
                        end
                        tgfb_pkg::OP_BRUSH: begin
                            // brush runs even with the center off the map
                            r_rad   <= signed'({1'b0, w_rad});
                            r_bdx   <= -signed'({1'b0, w_rad});
                            r_bdy   <= -signed'({1'b0, w_rad});
                            r_state <= S_BRUSH;
                        end
                        tgfb_pkg::OP_FILL: begin
                            r_state <= w_inside ? S_FSEED : S_RESULT;
                        end
                        default: begin
                            r_state <= S_RESULT;
                        end
                    endcase
                end
                S_RDWAIT: begin
                    r_res_tile <= r_grid_rd[tgfb_pkg::TILE_W-1:0];
                    r_state    <= S_RESULT;
                end
                S_BRUSH: begin
                    if (w_inside) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_bdx == r_rad) begin
                        r_bdx <= -r_rad;
                        if (r_bdy == r_rad) begin
                            r_state <= S_RESULT;
                        end else begin
                            r_bdy <= r_bdy + 1'b1;
                        end
                    end else begin
                        r_bdx <= r_bdx + 1'b1;
                    end
                end
                S_FSEED: begin
                    r_old <= r_grid_rd;
                    if (r_grid_rd == r_tile) begin
                        r_res_status <= tgfb_pkg::ST_NO_CHANGE;
                        r_state      <= S_RESULT;
                    end else begin
                        r_cnt   <= CNTW'(1);
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_state <= (w_stk_cnt == '0) ? S_RESULT : S_PWAIT;
                end
                S_PWAIT: begin
                    r_cx    <= CXW'(w_stk_rd[XW-1:0]);
                    r_cy    <= CYW'(w_stk_rd[SW-1:XW]);
                    r_dir   <= '0;
                    r_state <= S_NREAD;
                end
                S_NREAD: begin
                    if (w_inside) begin
                        r_state <= S_NCHK;
                    end else if (r_dir == 2'd3) begin
                        r_state <= S_POP;
                    end else begin
                        r_dir <= r_dir + 1'b1;
                    end
                end
                S_NCHK: begin
                    if (w_match && w_room) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_dir == 2'd3) begin
                        r_state <= S_POP;
                    end else begin
                        r_dir   <= r_dir + 1'b1;
                        r_state <= S_NREAD;
                    end
                end
                S_RESULT: begin
                    // wait until the output register is free
                    if (w_res_load) begin
                        r_out_tile   <= r_res_tile;
                        r_out_status <= r_res_status;
                        r_out_cnt    <= tgfb_pkg::COUNT_W'(r_cnt);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_read_tile     = r_out_tile;
    assign o_status        = r_out_status;
    assign o_cells_changed = r_out_cnt;

endmodule

// File: rtl/core/tgfb_checker.sv
`timescale 1ns / 1ps
// port-level checks for the tile grid unit, bound to the top level
// depends on tgfb_pkg and tile_grid_fill_and_brush_unit

module tgfb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [tgfb_pkg::TILE_W-1:0]        o_read_tile,
    input logic [tgfb_pkg::STATUS_W-1:0]      o_status,
    input logic [tgfb_pkg::COUNT_W-1:0]       o_cells_changed
);

    // a result held back keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_cells_changed) &&
            $stable(o_read_tile))
        else $error("stalled result changed");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    // a fill without effect changes nothing and reads nothing
    a_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == tgfb_pkg::ST_NO_CHANGE) |->
            (o_cells_changed == '0) && (o_read_tile == '0))
        else $error("no-change result with data");

    // only a read in the map returns a tile code
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_tile != '0) |->
            (o_status == tgfb_pkg::ST_DONE) && (o_cells_changed == '0))
        else $error("tile code on a non-read result");

endmodule

bind tile_grid_fill_and_brush_unit tgfb_checker u_tgfb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_read_tile     (o_read_tile),
    .o_status        (o_status),
    .o_cells_changed (o_cells_changed)
);
